// ----- rtl/dda_pkg.sv -----
// Shared types, register indexes and the per-axis step function of the DDA line rasterizer.
// Used by the controller, the datapath and the top level. No dependencies.
package dda_pkg;

  // Configuration port widths.
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 7;

  // Register indexes of the configuration port.
  localparam logic [CfgIdxW-1:0] RegBoardWidth  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegBoardHeight = 2'd1;

  // Fixed field widths.
  localparam int unsigned CoordW = 6;
  localparam int unsigned CharW  = 8;
  localparam int unsigned RemW   = CoordW + 1;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;
    logic advance;
  } dda_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic last;
  } dda_sts_t;

  // One axis: coordinate and rounding remainder.
  typedef struct packed {
    logic [CoordW-1:0] coord;
    logic [RemW-1:0]   rem;
  } dda_axis_t;

  // Moves one axis by one point. The invariant 2*num + steps = coord*2*steps + rem
  // with 0 <= rem < 2*steps holds before and after, and |delta| <= steps keeps the
  // coordinate change to at most one.
  function automatic dda_axis_t dda_axis_step(input dda_axis_t   cur,
                                              input logic [RemW-1:0] d2,
                                              input logic [RemW-1:0] s2,
                                              input logic          dec);
    dda_axis_t    nxt;
    logic [RemW:0] sum;
    logic [RemW:0] diff;
    nxt  = cur;
    sum  = {1'b0, cur.rem} + {1'b0, d2};
    diff = {1'b0, cur.rem} - {1'b0, d2};
    if (!dec) begin
      if (sum >= {1'b0, s2}) begin
        nxt.rem   = RemW'(sum - {1'b0, s2});
        nxt.coord = cur.coord + CoordW'(1);
      end else begin
        nxt.rem = RemW'(sum);
      end
    end else begin
      if (diff[RemW]) begin
        nxt.rem   = RemW'(diff + {1'b0, s2});
        nxt.coord = cur.coord - CoordW'(1);
      end else begin
        nxt.rem = RemW'(diff);
      end
    end
    return nxt;
  endfunction

endpackage

// ----- rtl/dda_ctrl.sv -----
// Controller state machine of the DDA line rasterizer: sequences line intake and point output.
// Depends on dda_pkg for the command and status types.
module dda_ctrl import dda_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output dda_cmd_t cmd_o,
  input  dda_sts_t sts_i
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_RUN  = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic   out_fire;
  logic   in_fire;
  logic   can_take;

  // A new line is taken when idle or while the last point of the current line leaves.
  assign out_valid_o = (state_q == S_RUN);
  assign out_fire    = out_valid_o && !out_stall_i;
  assign can_take    = (state_q == S_IDLE) || (out_fire && sts_i.last);
  assign in_stall_o  = !can_take;
  assign in_fire     = in_valid_i && can_take;

  assign cmd_o.load    = in_fire;
  assign cmd_o.advance = out_fire && !sts_i.last;

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire) state_d = S_RUN;
      end
      S_RUN: begin
        if (out_fire && sts_i.last && !in_fire) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // A point that is stalled keeps the controller running.
  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RUN && out_stall_i) |=> (state_q == S_RUN))
    else $error("controller left RUN while a point was stalled");

  // A line is never taken while points of the previous one remain.
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.load && state_q == S_RUN) |-> (out_fire && sts_i.last))
    else $error("line accepted before the previous line finished");

  // Load and advance never coincide.
  a_cmd_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.load && cmd_o.advance))
    else $error("load and advance asserted together");

endmodule

// ----- rtl/dda_datapath.sv -----
// Datapath of the DDA line rasterizer: per-axis coordinate and remainder registers, step counter.
// Depends on dda_pkg for field widths, command and status types and the axis step function.
module dda_datapath import dda_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dda_cmd_t          cmd_i,
  output dda_sts_t          sts_o,
  input  logic [CoordW-1:0] start_x_i,
  input  logic [CoordW-1:0] start_y_i,
  input  logic [CoordW-1:0] end_x_i,
  input  logic [CoordW-1:0] end_y_i,
  input  logic [CharW-1:0]  draw_char_i,
  output logic [CoordW-1:0] pixel_x_o,
  output logic [CoordW-1:0] pixel_y_o,
  output logic [CharW-1:0]  pixel_char_o
);

  dda_axis_t         ax_q, ax_d, ay_q, ay_d;
  logic [RemW-1:0]   dx2_q, dx2_d, dy2_q, dy2_d;
  logic [RemW-1:0]   s2_q, s2_d;
  logic              xdec_q, xdec_d, ydec_q, ydec_d;
  logic [CoordW-1:0] cnt_q, cnt_d;
  logic [CharW-1:0]  char_q, char_d;

  logic [CoordW-1:0] adx, ady, steps;
  logic              x_dec, y_dec;

  // Line setup: absolute deltas, direction and the step count.
  always_comb begin
    x_dec = start_x_i > end_x_i;
    y_dec = start_y_i > end_y_i;
    adx   = x_dec ? (start_x_i - end_x_i) : (end_x_i - start_x_i);
    ady   = y_dec ? (start_y_i - end_y_i) : (end_y_i - start_y_i);
    steps = (adx > ady) ? adx : ady;
  end

  // Load a new line or move to the next point.
  always_comb begin
    ax_d   = ax_q;
    ay_d   = ay_q;
    dx2_d  = dx2_q;
    dy2_d  = dy2_q;
    s2_d   = s2_q;
    xdec_d = xdec_q;
    ydec_d = ydec_q;
    cnt_d  = cnt_q;
    char_d = char_q;
    if (cmd_i.load) begin
      ax_d.coord = start_x_i;
      ax_d.rem   = {1'b0, steps};
      ay_d.coord = start_y_i;
      ay_d.rem   = {1'b0, steps};
      dx2_d      = {adx, 1'b0};
      dy2_d      = {ady, 1'b0};
      s2_d       = {steps, 1'b0};
      xdec_d     = x_dec;
      ydec_d     = y_dec;
      cnt_d      = steps;
      char_d     = draw_char_i;
    end else if (cmd_i.advance) begin
      ax_d  = dda_axis_step(ax_q, dx2_q, s2_q, xdec_q);
      ay_d  = dda_axis_step(ay_q, dy2_q, s2_q, ydec_q);
      cnt_d = cnt_q - CoordW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ax_q   <= '0;
      ay_q   <= '0;
      dx2_q  <= '0;
      dy2_q  <= '0;
      s2_q   <= '0;
      xdec_q <= 1'b0;
      ydec_q <= 1'b0;
      cnt_q  <= '0;
      char_q <= '0;
    end else begin
      ax_q   <= ax_d;
      ay_q   <= ay_d;
      dx2_q  <= dx2_d;
      dy2_q  <= dy2_d;
      s2_q   <= s2_d;
      xdec_q <= xdec_d;
      ydec_q <= ydec_d;
      cnt_q  <= cnt_d;
      char_q <= char_d;
    end
  end

  assign sts_o.last   = (cnt_q == '0);
  assign pixel_x_o    = ax_q.coord;
  assign pixel_y_o    = ay_q.coord;
  assign pixel_char_o = char_q;

  // The rounding remainders stay below twice the step count.
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_q != '0) |-> (ax_q.rem < s2_q && ay_q.rem < s2_q))
    else $error("DDA remainder out of range");

  // A step moves each coordinate by at most one.
  a_unit_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.advance |=> ((ax_q.coord == $past(ax_q.coord) ||
                        ax_q.coord == $past(ax_q.coord) + CoordW'(1) ||
                        ax_q.coord == $past(ax_q.coord) - CoordW'(1)) &&
                       (ay_q.coord == $past(ay_q.coord) ||
                        ay_q.coord == $past(ay_q.coord) + CoordW'(1) ||
                        ay_q.coord == $past(ay_q.coord) - CoordW'(1))))
    else $error("DDA coordinate jumped by more than one");

  // Advance is never given at the last point of a line.
  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.advance |-> (cnt_q != '0))
    else $error("advance past the last point");

endmodule

// ----- rtl/dda_line_rasterizer_top.sv -----
// DDA line rasterizer, top level: configuration registers, clipping, controller and datapath.
// Depends on dda_pkg, dda_ctrl and dda_datapath.
//
// Each accepted line produces steps+1 point transactions, steps being the larger of the
// absolute x and y deltas, so 1 to 64 points per line. Points leave at one per cycle while
// the output is not stalled: the per-axis coordinate and remainder registers advance by one
// add and compare per cycle, exactly matching round-half-up of start + i*delta/steps. The next
// line is taken in the cycle its predecessor's last point is taken. Board width and height
// are to be written through the configuration port only while the block is idle; the block
// itself does not enforce this. Values above MAX_BOARD_SIZE act as MAX_BOARD_SIZE.
module dda_line_rasterizer_top import dda_pkg::*; #(
  parameter int unsigned MAX_BOARD_SIZE = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Configuration write channel.
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  // Line input channel.
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [CoordW-1:0]   start_x_i,
  input  logic [CoordW-1:0]   start_y_i,
  input  logic [CoordW-1:0]   end_x_i,
  input  logic [CoordW-1:0]   end_y_i,
  input  logic [CharW-1:0]    draw_char_i,
  // Point output channel.
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [CoordW-1:0]   pixel_x_o,
  output logic [CoordW-1:0]   pixel_y_o,
  output logic [CharW-1:0]    pixel_char_o,
  output logic                inside_board_o,
  output logic                last_point_o
);

  localparam logic [CfgDataW-1:0] MaxSize = CfgDataW'(MAX_BOARD_SIZE);

  logic [CfgDataW-1:0] width_q, width_d, height_q, height_d;
  logic [CfgDataW-1:0] width_lim, height_lim;
  dda_cmd_t            cmd;
  dda_sts_t            sts;

  // Configuration registers; writes to unknown indexes are dropped.
  assign cfg_ready_o = 1'b1;

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        RegBoardWidth:  width_d  = cfg_data_i;
        RegBoardHeight: height_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= MaxSize;
      height_q <= MaxSize;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
    end
  end

  // Clip sizes to the largest supported board.
  assign width_lim  = (width_q > MaxSize) ? MaxSize : width_q;
  assign height_lim = (height_q > MaxSize) ? MaxSize : height_q;

  dda_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  dda_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .start_x_i    (start_x_i),
    .start_y_i    (start_y_i),
    .end_x_i      (end_x_i),
    .end_y_i      (end_y_i),
    .draw_char_i  (draw_char_i),
    .pixel_x_o    (pixel_x_o),
    .pixel_y_o    (pixel_y_o),
    .pixel_char_o (pixel_char_o)
  );

  // Clipping and end-of-line flag for the point on the output.
  assign inside_board_o = ({1'b0, pixel_x_o} < width_lim) && ({1'b0, pixel_y_o} < height_lim);
  assign last_point_o   = sts.last;

endmodule
